// ===== rtl/nrf_pkg.sv =====
// nrf_pkg: shared constants and types for the nonce replay filter.
// FNV-1a 32 constants, nonce geometry and the table control struct.
// No dependencies.
package nrf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NONCE_BYTES = 12;
  localparam int unsigned NONCE_W     = NONCE_BYTES * BYTE_W;
  localparam int unsigned HASH_W      = 32;

  localparam logic [HASH_W-1:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } nrf_mem_ctl_t;

endpackage

// ===== rtl/nonce_replay_filter_unit.sv =====
// nonce_replay_filter_unit: replay cache for 96-bit nonces, FNV-1a 32 hash.
// From input accept to result valid: 12 hash rounds, 32 remainder steps,
// table read, compare/write. No new item is taken until a result is issued.
// Reset: a clearing pass over every slot zeroes the occupied flags;
// no input item is accepted until it ends. Depends on nrf_pkg, nrf_hash,
// nrf_mod, nrf_table.
module nonce_replay_filter_unit #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] nonce_low_i,
  input  logic [31:0] nonce_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_replay_o
);
  import nrf_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_CMP   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [IW-1:0]      clr_addr_q, clr_addr_d;
  logic [NONCE_W-1:0] nonce_q;
  logic               out_valid_q, out_valid_d;
  logic               is_replay_q, is_replay_d;

  logic               in_acc;
  logic               out_free;
  logic               hash_done;
  logic [HASH_W-1:0]  hash;
  logic               mod_done;
  logic [IW-1:0]      slot;
  nrf_mem_ctl_t       mem_ctl;
  logic [IW-1:0]      mem_addr;
  logic [NONCE_W-1:0] rd_nonce;
  logic               rd_occ;
  logic               hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign hit        = rd_occ && (rd_nonce == nonce_q);

  nrf_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .nonce_i ({nonce_high_i, nonce_low_i}),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  nrf_mod #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_done),
    .hash_i  (hash),
    .done_o  (mod_done),
    .rem_o   (slot)
  );

  always_comb begin
    mem_ctl.clr = (state_q == ST_CLEAR);
    mem_ctl.rd  = (state_q == ST_READ);
    mem_ctl.wr  = (state_q == ST_CMP) && out_free && !hit;
    mem_addr    = (state_q == ST_CLEAR) ? clr_addr_q : slot;
  end

  nrf_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (nonce_q),
    .rdata_o (rd_nonce),
    .rocc_o  (rd_occ)
  );

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q;
    is_replay_d = is_replay_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == IW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          is_replay_d = hit;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_replay_q <= is_replay_d;
    if (in_acc) begin
      nonce_q <= {nonce_high_i, nonce_low_i};
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_replay_o = is_replay_q;

`ifndef ASSERT_OFF
  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (state_q == ST_HASH))
    else $error("hash done outside hash phase");

  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == ST_MOD))
    else $error("remainder done outside mod phase");

  a_write_only_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr |-> ((state_q == ST_CMP) && !hit && !mem_ctl.clr))
    else $error("table write outside a fresh compare");

  a_result_from_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_CMP))
    else $error("result raised outside compare");
`endif

endmodule

// ===== rtl/nrf_hash.sv =====
// nrf_hash: byte-serial FNV-1a 32 over a 96-bit nonce, one byte per cycle.
// Depends on nrf_pkg.
module nrf_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [nrf_pkg::NONCE_W-1:0] nonce_i,
  output logic                        done_o,
  output logic [nrf_pkg::HASH_W-1:0]  hash_o
);
  import nrf_pkg::*;

  localparam int unsigned CNT_W = $clog2(NONCE_BYTES);

  logic [NONCE_W-1:0] sr_q, sr_d;
  logic [HASH_W-1:0]  h_q, h_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [HASH_W-1:0]  mix;

  assign mix = h_q ^ {{(HASH_W-BYTE_W){1'b0}}, sr_q[BYTE_W-1:0]};

  always_comb begin
    sr_d   = sr_q;
    h_d    = h_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sr_d   = nonce_i;
      h_d    = FNV_OFFSET;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      h_d   = mix * FNV_PRIME;
      sr_d  = sr_q >> BYTE_W;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NONCE_BYTES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
    h_q  <= h_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;

endmodule

// ===== rtl/nrf_mod.sv =====
// nrf_mod: bit-serial remainder of the 32-bit hash by the table size,
// one hash bit per cycle, MSB first. Depends on nrf_pkg.
module nrf_mod #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [nrf_pkg::HASH_W-1:0]         hash_i,
  output logic                               done_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   rem_o
);
  import nrf_pkg::*;

  localparam int unsigned IW    = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(HASH_W);
  localparam logic [IW:0] MODULUS = (IW+1)'(TABLE_ENTRIES);

  logic [HASH_W-1:0] sr_q, sr_d;
  logic [IW-1:0]     r_q, r_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [IW:0]       t;
  logic [IW:0]       t_sub;

  assign t     = {r_q, sr_q[HASH_W-1]};
  assign t_sub = t - MODULUS;

  always_comb begin
    sr_d   = sr_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sr_d   = hash_i;
      r_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = (t >= MODULUS) ? t_sub[IW-1:0] : t[IW-1:0];
      sr_d  = sr_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(HASH_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
    r_q  <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ===== rtl/nrf_table.sv =====
// nrf_table: slot storage, a nonce memory and an occupied-flag memory,
// one port each, registered read. Depends on nrf_pkg.
module nrf_table #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                             clk_i,
  input  nrf_pkg::nrf_mem_ctl_t            ctl_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] addr_i,
  input  logic [nrf_pkg::NONCE_W-1:0]      wdata_i,
  output logic [nrf_pkg::NONCE_W-1:0]      rdata_o,
  output logic                             rocc_o
);
  import nrf_pkg::*;

  logic [NONCE_W-1:0] nonce_mem [TABLE_ENTRIES];
  logic               occ_mem   [TABLE_ENTRIES];
  logic [NONCE_W-1:0] rdata_q;
  logic               rocc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      nonce_mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= nonce_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      occ_mem[addr_i] <= 1'b0;
    end else if (ctl_i.wr) begin
      occ_mem[addr_i] <= 1'b1;
    end
    if (ctl_i.rd) begin
      rocc_q <= occ_mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign rocc_o  = rocc_q;

endmodule
